// ===== rtl/key_matrix_debounce_unit_assert.svh =====
// Assertion macros for the key matrix debounce unit
`ifndef KEY_MATRIX_DEBOUNCE_UNIT_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define KMD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KMD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KMD_ASSERT_IMP(lbl, ante, cons, msg)
`define KMD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/kmd_pkg.sv =====
// Shared constants for the key matrix debounce unit
`default_nettype none

package kmd_pkg;

	localparam int ROWS_DEF = 10;
	localparam int COLS_DEF = 5;

	localparam int ROW_W  = 4;
	localparam int COL_W  = 5;
	localparam int TIME_W = 32;
	localparam int DT_W   = 16;
	localparam int MASK_W = 50;
	localparam int KEY_W  = 6;
	localparam int KIDX_W = 7;
	localparam int CFG_W  = 50;
	localparam int CFG_IDX_W = 1;

	// per key: change time, debounced level, last raw level
	localparam int ENTRY_W = TIME_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 1'b1;

	localparam logic [DT_W-1:0]   DT_RESET   = 16'd5000;
	localparam logic [MASK_W-1:0] MASK_RESET = 50'd1125865580625951;

endpackage

`default_nettype wire

// ===== rtl/kmd_ram.sv =====
// Generic single write port RAM with registered read
`default_nettype none

module kmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kmd_update.sv =====
// Per-column debounce update of one matrix row entry
`default_nettype none

module kmd_update import kmd_pkg::*; #(
	parameter int COLS = COLS_DEF
) (
	input  wire logic                    row_ok,
	input  wire logic [KIDX_W-1:0]       base,
	input  wire logic [COL_W-1:0]        cols,
	input  wire logic [TIME_W-1:0]       now,
	input  wire logic [DT_W-1:0]         dt,
	input  wire logic [MASK_W-1:0]       mask,
	input  wire logic [COLS*ENTRY_W-1:0] entry_in,
	output logic      [COLS*ENTRY_W-1:0] entry_out,
	output logic      [COLS-1:0]         ev_mask,
	output logic      [COLS-1:0]         ev_lvl
);

	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [KIDX_W-1:0]  idx;
		logic               en;
		logic               raw;
		logic               last_raw;
		logic               stable;
		logic [TIME_W-1:0]  ct;
		logic [TIME_W-1:0]  elapsed;
		logic               ripe;
		logic [ENTRY_W-1:0] e_out;
		logic               ev;

		assign idx = base + KIDX_W'(c);
		assign en  = row_ok && (idx < KIDX_W'(MASK_W)) && mask[idx[KEY_W-1:0]];

		if (c < COL_W) begin : g_in
			assign raw = ~cols[c];
		end else begin : g_missing
			// absent column reads low, i.e. pressed
			assign raw = 1'b1;
		end

		assign last_raw = entry_in[c*ENTRY_W];
		assign stable   = entry_in[c*ENTRY_W + 1];
		assign ct       = entry_in[c*ENTRY_W + 2 +: TIME_W];
		assign elapsed  = now - ct;
		assign ripe     = elapsed > TIME_W'(dt);

		always_comb begin
			e_out = entry_in[c*ENTRY_W +: ENTRY_W];
			ev    = 1'b0;
			if (en) begin
				e_out[0] = raw;
				if (raw != last_raw) begin
					e_out[2 +: TIME_W] = now;
				end else if (raw != stable && ripe) begin
					e_out[1] = raw;
					ev       = 1'b1;
				end
			end
		end

		assign entry_out[c*ENTRY_W +: ENTRY_W] = e_out;
		assign ev_mask[c] = ev;
		assign ev_lvl[c]  = raw;
	end

endmodule

`default_nettype wire

// ===== rtl/kmd_emit.sv =====
// Event emitter: one key event per cycle from a row's event mask while out_ready is high
`default_nettype none

module kmd_emit import kmd_pkg::*; #(
	parameter int COLS = COLS_DEF,
	localparam int SEL_W = (COLS > 1) ? $clog2(COLS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [COLS-1:0]   ev_mask,
	input  wire logic [COLS-1:0]   ev_lvl,
	input  wire logic [KIDX_W-1:0] base,
	output logic                   take,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [KEY_W-1:0]  key_index,
	output logic                   pressed,
	output logic                   last_event
);

	logic [COLS-1:0]   mask_q;
	logic [COLS-1:0]   lvl_q;
	logic [KIDX_W-1:0] base_q;
	logic [SEL_W-1:0]  sel;
	logic [COLS-1:0]   pick;
	logic [COLS-1:0]   rest;
	logic [KIDX_W-1:0] kidx;

	always_comb begin
		sel  = '0;
		pick = '0;
		for (int i = COLS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel  = SEL_W'(i);
				pick = COLS'(1) << i;
			end
		end
	end

	assign rest       = mask_q & ~pick;
	assign out_valid  = |mask_q;
	assign last_event = ~|rest;
	assign kidx       = base_q + KIDX_W'(sel);
	assign key_index  = kidx[KEY_W-1:0];
	assign pressed    = lvl_q[sel];
	assign take       = !out_valid || (out_ready && last_event);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= ev_mask;
		end else if (out_valid && out_ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lvl_q  <= ev_lvl;
			base_q <= base;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_debounce_unit.sv =====
// Events of a row are offered from the emitter register once the row leaves the update stage.
// Throughput: one row per cycle when it raises no events; a row with events waits until
// the emitter is empty or taking its last event; events leave one per cycle under out_ready.
// State sits in a row-wide RAM (read, update, write back) with one-entry write forwarding.
// Reset: asynchronous, clears pipeline control and per-row valid bits so every key
// reads as released with change time zero; registers take their reset values.
`default_nettype none

`include "key_matrix_debounce_unit_assert.svh"

module key_matrix_debounce_unit import kmd_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ROW_W-1:0]     row,
	input  wire logic [COL_W-1:0]     column_bits,
	input  wire logic [TIME_W-1:0]    sample_time,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [KEY_W-1:0]     key_index,
	output logic                      pressed,
	output logic                      last_event
);

	localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RAM_W = COLS * ENTRY_W;

	logic [DT_W-1:0]   dt_q;
	logic [MASK_W-1:0] mask_q;

	logic              valid_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  cols_s1;
	logic [TIME_W-1:0] time_s1;

	logic              accept;
	logic              s1_adv;
	logic              in_range_s1;
	logic              row_vld;
	logic              fwd;
	logic              take;
	logic              ev_any;
	logic              ram_we;
	logic [KIDX_W-1:0] base_s1;
	logic [RAM_W-1:0]  rdata;
	logic [RAM_W-1:0]  entry_cur;
	logic [RAM_W-1:0]  entry_new;
	logic [COLS-1:0]   ev_mask;
	logic [COLS-1:0]   ev_lvl;

	logic [ROWS-1:0]   row_valid_q;
	logic              wb_valid_q;
	logic [AW-1:0]     wb_row_q;
	logic [RAM_W-1:0]  wb_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= DT_RESET;
			mask_q <= MASK_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE: dt_q   <= cfg_data[DT_W-1:0];
				REG_ENABLE:   mask_q <= cfg_data[MASK_W-1:0];
			endcase
		end
	end

	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1  <= row;
			cols_s1 <= column_bits;
			time_s1 <= sample_time;
		end
	end

	kmd_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_s1[AW-1:0]),
		.wdata (entry_new),
		.re    (accept),
		.raddr (row[AW-1:0]),
		.rdata (rdata)
	);

	assign in_range_s1 = {1'b0, row_s1} < (ROW_W + 1)'(ROWS);
	assign row_vld     = in_range_s1 && row_valid_q[row_s1[AW-1:0]];
	// a write in the cycle of our read left the RAM output stale
	assign fwd         = wb_valid_q && (wb_row_q == row_s1[AW-1:0]);
	assign entry_cur   = fwd ? wb_data_q : (row_vld ? rdata : '0);
	assign base_s1     = KIDX_W'(row_s1) * KIDX_W'(COLS);

	kmd_update #(
		.COLS (COLS)
	) u_update (
		.row_ok    (in_range_s1),
		.base      (base_s1),
		.cols      (cols_s1),
		.now       (time_s1),
		.dt        (dt_q),
		.mask      (mask_q),
		.entry_in  (entry_cur),
		.entry_out (entry_new),
		.ev_mask   (ev_mask),
		.ev_lvl    (ev_lvl)
	);

	assign ev_any = |ev_mask;
	assign s1_adv = valid_s1 && (!ev_any || take);
	assign ram_we = s1_adv && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			wb_valid_q  <= 1'b0;
		end else if (ram_we) begin
			row_valid_q[row_s1[AW-1:0]] <= 1'b1;
			wb_valid_q                  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wb_row_q  <= row_s1[AW-1:0];
			wb_data_q <= entry_new;
		end
	end

	kmd_emit #(
		.COLS (COLS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv && ev_any),
		.ev_mask    (ev_mask),
		.ev_lvl     (ev_lvl),
		.base       (base_s1),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_index  (key_index),
		.pressed    (pressed),
		.last_event (last_event)
	);

	`KMD_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(row_s1), "row lost")
	`KMD_ASSERT_IMP(a_we_range, ram_we, in_range_s1, "state write for an out-of-range row")
	`KMD_ASSERT_NXT(a_row_cont, out_valid && out_ready && !last_event, out_valid, "run broken")
	`KMD_ASSERT_IMP(a_no_ev_oor, valid_s1 && !in_range_s1, !ev_any, "event for bad row")

endmodule

`default_nettype wire

// ===== tb/key_matrix_debounce_unit_test.sv =====
// Self-checking testbench for the key matrix debounce unit: scanned rows in, key events out
`default_nettype none

module key_matrix_debounce_unit_test;
	import kmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NKEYS       = ROWS_DEF * COLS_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE      = 20;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             down;
		logic             is_last;
	} key_event_t;

	class debounce_scoreboard;
		bit               raw_level [NKEYS];
		bit               held_level[NKEYS];
		logic [TIME_W-1:0] changed_at[NKEYS];
		logic [DT_W-1:0]   hold_time;
		logic [MASK_W-1:0] enabled;
		key_event_t        awaited[$];
		int unsigned       errors;
		int unsigned       rows_taken;
		int unsigned       events_seen;

		function new();
			for (int k = 0; k < NKEYS; k++) begin
				raw_level[k]  = 1'b0;
				held_level[k] = 1'b0;
				changed_at[k] = '0;
			end
			hold_time   = DT_RESET;
			enabled     = MASK_RESET;
			errors      = 0;
			rows_taken  = 0;
			events_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_DEBOUNCE)
				hold_time = data[DT_W-1:0];
			else if (idx == REG_ENABLE)
				enabled = data[MASK_W-1:0];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// debounce one scanned row and queue the events it raises
		function void note_row(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
				logic [TIME_W-1:0] t);
			key_event_t batch[$];
			key_event_t ev;
			rows_taken++;
			if (r >= ROWS_DEF)
				return;
			for (int x = 0; x < COLS_DEF; x++) begin
				int k;
				bit lvl;
				logic [TIME_W-1:0] held;
				k = int'(r) * COLS_DEF + x;
				if (!enabled[k])
					continue;
				lvl  = ~c[x];
				held = t - changed_at[k];
				if (lvl != raw_level[k]) begin
					changed_at[k] = t;
				end else if (lvl != held_level[k] && held > TIME_W'(hold_time)) begin
					held_level[k] = lvl;
					ev.key     = KEY_W'(k);
					ev.down    = lvl;
					ev.is_last = 1'b0;
					batch.insert(batch.size(), ev);
				end
				raw_level[k] = lvl;
			end
			if (batch.size() > 0)
				batch[batch.size()-1].is_last = 1'b1;
			foreach (batch[i])
				awaited.insert(awaited.size(), batch[i]);
		endfunction

		function void check_event(logic [KEY_W-1:0] k, logic p, logic l);
			key_event_t want;
			events_seen++;
			if (awaited.size() == 0) begin
				$display("%0t: expected no event, got key_index %0d pressed %0d last_event %0d",
					$time, k, p, l);
				errors++;
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			if (k !== want.key) begin
				$display("%0t: key_index expected %0d got %0d", $time, want.key, k);
				errors++;
			end
			if (p !== want.down) begin
				$display("%0t: pressed expected %0d got %0d (key %0d)",
					$time, want.down, p, want.key);
				errors++;
			end
			if (l !== want.is_last) begin
				$display("%0t: last_event expected %0d got %0d (key %0d)",
					$time, want.is_last, l, want.key);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [ROW_W-1:0]     row;
	logic [COL_W-1:0]     column_bits;
	logic [TIME_W-1:0]    sample_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [KEY_W-1:0]     key_index;
	logic                 pressed;
	logic                 last_event;

	debounce_scoreboard sb;
	int unsigned        send_idle;
	int unsigned        recv_idle;
	int unsigned        hold_len;
	int unsigned        quiet;
	logic [TIME_W-1:0]  now_us;
	bit                 contact[NKEYS];

	key_matrix_debounce_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row         (row),
		.column_bits (column_bits),
		.sample_time (sample_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_index   (key_index),
		.pressed     (pressed),
		.last_event  (last_event)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random back-pressure, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_len = hold_len - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_event(key_index, pressed, last_event);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_row(logic [ROW_W-1:0] r, logic [COL_W-1:0] c, logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		row         <= r;
		column_bits <= c;
		sample_time <= t;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_row(r, c, t);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_regs(logic [DT_W-1:0] dt, logic [MASK_W-1:0] mask);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_DEBOUNCE;
		cfg_data     <= CFG_W'(dt);
		@(negedge clk);
		cfg_index    <= REG_ENABLE;
		cfg_data     <= CFG_W'(mask);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		sb.set_reg(REG_DEBOUNCE, CFG_W'(dt));
		sb.set_reg(REG_ENABLE, CFG_W'(mask));
	endtask

	// mostly in-order scans of bouncing contacts, with some noise rows
	task automatic run_scan(int unsigned n, int unsigned step_max);
		int unsigned in_range;
		int unsigned r;
		logic [ROW_W-1:0] rr;
		logic [COL_W-1:0] c;
		in_range = 0;
		r = 0;
		while (in_range < n) begin
			if ($urandom_range(99) < 6) begin
				rr     = ROW_W'($urandom_range(15));
				c      = COL_W'($urandom);
				now_us = $urandom;
			end else begin
				if ($urandom_range(99) < 10)
					r = $urandom_range(ROWS_DEF - 1);
				else
					r = (r + 1) % ROWS_DEF;
				rr     = ROW_W'(r);
				now_us = now_us + $urandom_range(step_max);
				for (int x = 0; x < COLS_DEF; x++) begin
					int k;
					k = r * COLS_DEF + x;
					if ($urandom_range(99) < 12)
						contact[k] = ~contact[k];
					c[x] = ~contact[k] ^ ($urandom_range(99) < 8);
				end
			end
			send_row(rr, c, now_us);
			if (rr < ROWS_DEF)
				in_range++;
		end
	endtask

	initial begin
		logic [DT_W-1:0] dt;
		sb           = new();
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = REG_DEBOUNCE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		row          = '0;
		column_bits  = '1;
		sample_time  = '0;
		out_ready    = 1'b0;
		send_idle    = 17;
		recv_idle    = 79;
		hold_len     = 0;
		quiet        = 0;
		now_us       = '0;
		for (int k = 0; k < NKEYS; k++)
			contact[k] = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, threshold edge, out-of-range rows, wrap
		send_row(4'd0, 5'h1F, 32'd0);
		send_row(4'd0, 5'h00, 32'd100);
		send_row(4'd0, 5'h00, 32'd5100);
		send_row(4'd0, 5'h00, 32'd5101);
		send_row(4'd9, 5'h0A, 32'd200);
		send_row(4'd9, 5'h0A, 32'd5201);
		send_row(4'd10, 5'h00, 32'd6000);
		send_row(4'd15, 5'h00, 32'd6000);
		send_row(4'd0, 5'h1F, 32'd20000);
		send_row(4'd0, 5'h1F, 32'd25001);
		send_row(4'd5, 5'h00, 32'hFFFF_F000);
		send_row(4'd5, 5'h00, 32'h0000_1000);
		send_row(4'd3, 5'h15, 32'hFFFF_FFFF);
		send_row(4'd3, 5'h15, 32'hFFFF_FFFF);
		send_row(4'd3, 5'h0A, 32'h0000_1000);
		send_row(4'd3, 5'h15, 32'h0000_2000);
		send_row(4'd3, 5'h15, 32'h0000_4000);
		send_row(4'd7, 5'h00, 32'd0);
		send_row(4'd7, 5'h00, 32'hFFFF_FFFF);
		send_row(4'd8, 5'h1F, 32'h8000_0000);
		drain();

		// zero debounce, every key on; receiver holds off while rows pile up
		write_regs(16'd0, {MASK_W{1'b1}});
		@(posedge clk);
		hold_len = 300;
		@(negedge clk);
		run_scan(130, 3);
		drain();

		send_idle = 79;
		recv_idle = 17;
		write_regs(16'hFFFF, MASK_W'({$urandom, $urandom}));
		now_us = $urandom;
		run_scan(130, 16000);
		drain();

		send_idle = 0;
		recv_idle = 0;
		dt = DT_W'($urandom_range(200, 1));
		write_regs(dt, MASK_RESET);
		run_scan(130, dt / 3 + 1);
		drain();

		write_regs(DT_RESET, '0);
		run_scan(15, 2000);
		drain();

		$display("Sent %0d rows over five register settings, checked %0d key events",
			sb.rows_taken, sb.events_seen);
		$display("Settings spanned zero and full debounce time, empty and full enable mask");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
